### rtl/fdpa_pkg.sv
package fdpa_pkg;

   localparam int LANES = 8;
   localparam int CNT_W = $clog2(LANES);
   localparam int EXP_W = 12;

   typedef logic [31:0] word_type;

   localparam word_type QNAN     = 32'h7FC0_0000;
   localparam word_type ONE_BITS = 32'h3F80_0000;
   localparam word_type NEG_ZERO = 32'h8000_0000;
   localparam word_type POS_INF  = 32'h7F80_0000;

   typedef struct packed {
      logic start;
      logic clear;
   } lane_ctrl_type;

   typedef struct packed {
      word_type [LANES-1:0] sums;
      word_type [LANES-1:0] a;
      word_type [LANES-1:0] b;
      logic [CNT_W-1:0]     tail_cnt;
      word_type             c_in;
   } merge_job_type;

   function automatic logic [5:0] msb64(input logic [63:0] v);
      logic [5:0] m;
      m = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            m = 6'(i);
         end
      end
      return m;
   endfunction

   function automatic logic signed [EXP_W-1:0] unbias(input logic [7:0] e);
      logic signed [EXP_W-1:0] x;
      if (e == 8'd0) begin
         x = -12'sd149;
      end else begin
         x = $signed({4'b0, e}) - 12'sd150;
      end
      return x;
   endfunction

endpackage

### rtl/fdpa_fma.sv
module fdpa_fma import fdpa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  word_type a,
   input  word_type b,
   input  word_type c,
   output logic     out_valid,
   output word_type result
);

   logic [30:0] aa, ab, ac;
   logic        sp, sc;
   logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
   logic        spec;
   word_type    spec_val;
   logic [23:0] sa, sb, scs;
   logic [47:0] prod;
   logic signed [EXP_W-1:0] ep, ec;

   logic        v1_ff, spec1_ff, sp1_ff, sc1_ff, cz1_ff;
   word_type    specv1_ff;
   logic [47:0] prod1_ff;
   logic [23:0] cs1_ff;
   logic signed [EXP_W-1:0] ep1_ff, ec1_ff;

   logic [5:0]  dp, dc;
   logic [63:0] pn_w, csn_w;
   logic signed [EXP_W-1:0] epn, ecn;

   logic        v2_ff, spec2_ff, sp2_ff, sc2_ff, cz2_ff;
   word_type    specv2_ff;
   logic [61:0] pn2_ff, csn2_ff;
   logic signed [EXP_W-1:0] ep2_ff, ec2_ff;

   logic [61:0] big, little, sm, shd;
   logic signed [EXP_W-1:0] xb, d;
   logic        sbg, ssm, sgn;
   logic [62:0] s;

   logic        v3_ff, spec3_ff, sg3_ff;
   word_type    specv3_ff;
   logic [62:0] s3_ff;
   logic signed [EXP_W-1:0] x3_ff;

   logic [5:0]  m;
   logic signed [EXP_W-1:0] shift, minsh;

   logic        v4_ff, spec4_ff, sg4_ff;
   word_type    specv4_ff;
   logic [62:0] s4_ff;
   logic signed [EXP_W-1:0] x4_ff, sh4_ff;

   logic signed [EXP_W-1:0] sh, nsh, biased;
   logic [63:0] s64, qv, mask, rem, half;
   logic [5:0]  amt;
   word_type    packed_res, res_in;

   logic        out_valid_ff;
   word_type    result_ff;

   assign aa     = a[30:0];
   assign ab     = b[30:0];
   assign ac     = c[30:0];
   assign sp     = a[31] ^ b[31];
   assign sc     = c[31];
   assign a_nan  = aa > POS_INF[30:0];
   assign b_nan  = ab > POS_INF[30:0];
   assign c_nan  = ac > POS_INF[30:0];
   assign a_inf  = aa == POS_INF[30:0];
   assign b_inf  = ab == POS_INF[30:0];
   assign c_inf  = ac == POS_INF[30:0];
   assign a_zero = aa == 31'd0;
   assign b_zero = ab == 31'd0;
   assign c_zero = ac == 31'd0;

   always_comb begin
      spec     = 1'b1;
      spec_val = '0;
      if (a_nan || b_nan || c_nan) begin
         spec_val = QNAN;
      end else if (a_inf || b_inf) begin
         if (a_zero || b_zero) begin
            spec_val = QNAN;
         end else if (c_inf && (sc != sp)) begin
            spec_val = QNAN;
         end else begin
            spec_val = {sp, POS_INF[30:0]};
         end
      end else if (c_inf) begin
         spec_val = c;
      end else if (a_zero || b_zero) begin
         if (c_zero) begin
            spec_val = {sp & sc, 31'd0};
         end else begin
            spec_val = c;
         end
      end else begin
         spec = 1'b0;
      end
   end

   assign sa   = {a[30:23] != 8'd0, a[22:0]};
   assign sb   = {b[30:23] != 8'd0, b[22:0]};
   assign scs  = {c[30:23] != 8'd0, c[22:0]};
   assign prod = sa * sb;
   assign ep   = unbias(a[30:23]) + unbias(b[30:23]);
   assign ec   = unbias(c[30:23]);

   assign dp    = 6'd61 - msb64({16'd0, prod1_ff});
   assign pn_w  = {16'd0, prod1_ff} << dp;
   assign epn   = ep1_ff - $signed({6'd0, dp});
   assign dc    = 6'd61 - msb64({40'd0, cs1_ff});
   assign csn_w = {40'd0, cs1_ff} << dc;
   assign ecn   = ec1_ff - $signed({6'd0, dc});

   always_comb begin
      if (ep2_ff >= ec2_ff) begin
         big = pn2_ff;  xb = ep2_ff; sbg = sp2_ff;
         little = csn2_ff; ssm = sc2_ff; d = ep2_ff - ec2_ff;
      end else begin
         big = csn2_ff; xb = ec2_ff; sbg = sc2_ff;
         little = pn2_ff; ssm = sp2_ff; d = ec2_ff - ep2_ff;
      end
      shd = little >> d[5:0];
      if (d >= 12'sd62) begin
         sm = 62'd1;
      end else if (d > 12'sd0) begin
         sm = shd | 62'((shd << d[5:0]) != little);
      end else begin
         sm = little;
      end
      if (cz2_ff) begin
         s   = {1'b0, pn2_ff};
         xb  = ep2_ff;
         sgn = sp2_ff;
      end else if (sbg == ssm) begin
         s   = {1'b0, big} + {1'b0, sm};
         sgn = sbg;
      end else if (big >= sm) begin
         s   = {1'b0, big} - {1'b0, sm};
         sgn = sbg;
      end else begin
         s   = {1'b0, sm} - {1'b0, big};
         sgn = ssm;
      end
   end

   assign m     = msb64({1'b0, s3_ff});
   assign minsh = -12'sd149 - x3_ff;
   always_comb begin
      shift = $signed({6'd0, m}) - 12'sd23;
      if (shift < minsh) begin
         shift = minsh;
      end
   end

   always_comb begin
      sh   = sh4_ff;
      s64  = {1'b0, s4_ff};
      nsh  = -sh4_ff;
      amt  = sh4_ff[5:0];
      mask = (64'd1 << amt) - 64'd1;
      rem  = s64 & mask;
      half = 64'd1 << (amt - 6'd1);
      qv   = '0;
      if (sh <= 12'sd0) begin
         qv = s64 << nsh[5:0];
      end else if (sh >= 12'sd64) begin
         qv = '0;
      end else begin
         qv = s64 >> amt;
         if ((rem > half) || ((rem == half) && qv[0])) begin
            qv = qv + 64'd1;
         end
      end
      if (qv == (64'd1 << 24)) begin
         qv = qv >> 1;
         sh = sh + 12'sd1;
      end
      biased = x4_ff + sh + 12'sd150;
      if (qv < (64'd1 << 23)) begin
         packed_res = {sg4_ff, 8'd0, qv[22:0]};
      end else if (biased >= 12'sd255) begin
         packed_res = {sg4_ff, POS_INF[30:0]};
      end else begin
         packed_res = {sg4_ff, biased[7:0], qv[22:0]};
      end
      res_in = spec4_ff ? specv4_ff : packed_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_valid_ff <= v4_ff;
      end
      spec1_ff  <= spec;
      specv1_ff <= spec_val;
      prod1_ff  <= prod;
      ep1_ff    <= ep;
      cs1_ff    <= scs;
      ec1_ff    <= ec;
      sp1_ff    <= sp;
      sc1_ff    <= sc;
      cz1_ff    <= c_zero;

      spec2_ff  <= spec1_ff;
      specv2_ff <= specv1_ff;
      pn2_ff    <= pn_w[61:0];
      csn2_ff   <= csn_w[61:0];
      ep2_ff    <= epn;
      ec2_ff    <= ecn;
      sp2_ff    <= sp1_ff;
      sc2_ff    <= sc1_ff;
      cz2_ff    <= cz1_ff;

      spec3_ff  <= spec2_ff || (s == 63'd0);
      specv3_ff <= spec2_ff ? specv2_ff : 32'd0;
      s3_ff     <= s;
      x3_ff     <= xb;
      sg3_ff    <= sgn;

      spec4_ff  <= spec3_ff;
      specv4_ff <= specv3_ff;
      s4_ff     <= s3_ff;
      x4_ff     <= x3_ff;
      sg4_ff    <= sg3_ff;
      sh4_ff    <= shift;

      result_ff <= res_in;
   end

   assign out_valid = out_valid_ff;
   assign result    = result_ff;

endmodule

### rtl/fdpa_lane.sv
module fdpa_lane import fdpa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  word_type      a,
   input  word_type      b,
   output word_type      sum,
   output word_type      result,
   output logic          done
);

   word_type acc_ff;

   fdpa_fma u_fma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ctrl.start),
      .a         (a),
      .b         (b),
      .c         (acc_ff),
      .out_valid (done),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (done) begin
         acc_ff <= result;
      end
   end

   assign sum = acc_ff;

endmodule

### rtl/fdpa_merge.sv
module fdpa_merge import fdpa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  merge_job_type job,
   output logic          idle,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output word_type      rsp_tdata
);

   localparam logic [4:0] STEP_P0   = 5'd0;
   localparam logic [4:0] STEP_P1   = 5'd1;
   localparam logic [4:0] STEP_P2   = 5'd2;
   localparam logic [4:0] STEP_P3   = 5'd3;
   localparam logic [4:0] STEP_Q0   = 5'd4;
   localparam logic [4:0] STEP_Q1   = 5'd5;
   localparam logic [4:0] STEP_SUM  = 5'd6;
   localparam logic [4:0] STEP_TAIL = 5'd7;

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_type;

   state_type        state_ff;
   word_type         r_ff  [LANES];
   word_type         ta_ff [LANES];
   word_type         tb_ff [LANES];
   logic [CNT_W-1:0] cnt_ff;
   word_type         cin_ff;
   logic [4:0]       step_ff;
   logic             rsp_tvalid_ff;
   word_type         rsp_tdata_ff;

   logic [4:0]       final_step, k;
   word_type         op_a, op_b, op_c, fma_res;
   logic [CNT_W-1:0] dst;
   logic             fma_done;

   assign final_step = STEP_TAIL + {1'b0, cnt_ff, 1'b0};
   assign k          = step_ff - STEP_TAIL;

   always_comb begin
      op_a = cin_ff;
      op_b = ONE_BITS;
      op_c = r_ff[0];
      dst  = CNT_W'(0);
      if (step_ff == final_step) begin
         op_a = cin_ff;
      end else if (step_ff >= STEP_TAIL) begin
         if (!k[0]) begin
            op_a = ta_ff[k[3:1]];
            op_b = tb_ff[k[3:1]];
            op_c = NEG_ZERO;
            dst  = CNT_W'(1);
         end else begin
            op_a = r_ff[0];
            op_c = r_ff[1];
         end
      end else begin
         case (step_ff)
            STEP_P0: begin op_a = r_ff[0]; op_c = r_ff[4]; dst = CNT_W'(0); end
            STEP_P1: begin op_a = r_ff[1]; op_c = r_ff[5]; dst = CNT_W'(1); end
            STEP_P2: begin op_a = r_ff[2]; op_c = r_ff[6]; dst = CNT_W'(2); end
            STEP_P3: begin op_a = r_ff[3]; op_c = r_ff[7]; dst = CNT_W'(3); end
            STEP_Q0: begin op_a = r_ff[0]; op_c = r_ff[1]; dst = CNT_W'(0); end
            STEP_Q1: begin op_a = r_ff[2]; op_c = r_ff[3]; dst = CNT_W'(2); end
            STEP_SUM: begin op_a = r_ff[0]; op_c = r_ff[2]; dst = CNT_W'(0); end
            default: begin op_a = r_ff[0]; op_c = r_ff[4]; dst = CNT_W'(0); end
         endcase
      end
   end

   fdpa_fma u_fma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (state_ff == ST_ISSUE),
      .a         (op_a),
      .b         (op_b),
      .c         (op_c),
      .out_valid (fma_done),
      .result    (fma_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && state_ff != ST_OUT) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  for (int i = 0; i < LANES; i++) begin
                     r_ff[i]  <= job.sums[i];
                     ta_ff[i] <= job.a[i];
                     tb_ff[i] <= job.b[i];
                  end
                  cnt_ff   <= job.tail_cnt;
                  cin_ff   <= job.c_in;
                  step_ff  <= STEP_P0;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (fma_done) begin
                  r_ff[dst] <= fma_res;
                  if (step_ff == final_step) begin
                     state_ff <= ST_OUT;
                  end else begin
                     step_ff  <= step_ff + 5'd1;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff  <= r_ff[0];
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign idle       = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      fma_done |-> state_ff == ST_WAIT)
      else $error("Merge unit result arrived outside the wait state.");

   a_issue_then_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |=> state_ff == ST_WAIT)
      else $error("Merge unit did not wait after issuing an operation.");

endmodule

### rtl/float_dot_product_accumulate.sv
// Binary32 dot-product-and-accumulate: eight lanes each fold one A*B pair per full
// transfer into their own accumulator with a pipelined fused multiply-add and a
// write-back; a full transfer (eight pairs) holds off the next one until the lanes are
// done, while a transfer with no full group does not start the lanes. A last transfer
// hands the lane sums to a merge unit that reduces them, adds the tail pairs and c_in
// on one shared fused multiply-add in 8 + 2 * tail operations, one at a time. The lanes
// take the next dot product meanwhile; only the next last transfer waits for the merge
// unit to be free.
module float_dot_product_accumulate import fdpa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_pair0 to a_pair7, b_pair0 to b_pair7,
   // pair_count, c_in, zero fill
   input  logic [551:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // c_out
   output logic [31:0]  rsp_tdata
);

   localparam int B_LSB   = LANES * 32;
   localparam int CNT_LSB = 2 * LANES * 32;
   localparam int CIN_LSB = CNT_LSB + 4;

   logic          busy_ff, pend_last_ff;
   word_type      cin_ff;
   logic          accept, full, lanes_done, merge_idle, merge_start;
   lane_ctrl_type lane_ctrl;
   merge_job_type job;
   word_type      lane_sum  [LANES];
   word_type      lane_res  [LANES];
   logic [LANES-1:0] lane_done;

   assign full       = req_tdata[CNT_LSB+3];
   assign req_tready = !busy_ff && (!req_tlast || merge_idle);
   assign accept     = req_tvalid && req_tready;
   assign lanes_done = &lane_done;
   assign merge_start = (accept && req_tlast && !full) || (lanes_done && pend_last_ff);

   assign lane_ctrl.start = accept && full;
   assign lane_ctrl.clear = merge_start;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      fdpa_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .a      (req_tdata[32*g +: 32]),
         .b      (req_tdata[B_LSB + 32*g +: 32]),
         .sum    (lane_sum[g]),
         .result (lane_res[g]),
         .done   (lane_done[g])
      );
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         job.sums[i] = lanes_done ? lane_res[i] : lane_sum[i];
         job.a[i]    = req_tdata[32*i +: 32];
         job.b[i]    = req_tdata[B_LSB + 32*i +: 32];
      end
      job.tail_cnt = lanes_done ? '0 : req_tdata[CNT_LSB +: CNT_W];
      job.c_in     = lanes_done ? cin_ff : req_tdata[CIN_LSB +: 32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
      end else if (lane_ctrl.start) begin
         busy_ff      <= 1'b1;
         pend_last_ff <= req_tlast;
      end else if (lanes_done) begin
         busy_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cin_ff <= req_tdata[CIN_LSB +: 32];
      end
   end

   fdpa_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .start      (merge_start),
      .job        (job),
      .idle       (merge_idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      lanes_done |-> busy_ff)
      else $error("Lane result without a full transfer in flight.");

   a_merge_free: assert property (@(posedge clock) disable iff (reset)
      merge_start |-> merge_idle)
      else $error("Merge unit started while busy.");

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> lanes_done)
      else $error("Lanes finished out of step.");

endmodule
